// File: rtl/core/sfa_pkg.sv
// shared types and codes for the segment fit allocator
// no dependencies; sfa_engine, the top level and the testbench import it
package sfa_pkg;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NOFIT   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    STRAT_FIRST = 2'd0,
    STRAT_BEST  = 2'd1,
    STRAT_WORST = 2'd2,
    STRAT_NEXT  = 2'd3
  } strategy_t;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

endpackage

// File: rtl/core/sfa_ifs.sv
// valid/ready channel interfaces of the segment fit allocator
// request, result and configuration write; depends on nothing
interface sfa_req_if #(parameter int UB = 16);
  logic          valid;
  logic          ready;
  logic          mode;
  logic [1:0]    strategy;
  logic [UB-1:0] request_size;
  logic [UB-1:0] block_offset;
  modport source(output valid, mode, strategy, request_size, block_offset, input ready);
  modport sink(input valid, mode, strategy, request_size, block_offset, output ready);
endinterface

interface sfa_rsp_if #(parameter int UB = 16);
  logic          valid;
  logic          ready;
  logic [1:0]    status;
  logic [UB-1:0] result_offset;
  logic [UB-1:0] result_size;
  modport source(output valid, status, result_offset, result_size, input ready);
  modport sink(input valid, status, result_offset, result_size, output ready);
endinterface

interface sfa_cfg_if #(parameter int UB = 16);
  logic          valid;
  logic          ready;
  logic [UB-1:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// File: rtl/core/sfa_seg_mem.sv
// segment table storage: one write port, one read port, registered read data
// no package dependencies
module sfa_seg_mem #(
  parameter int DEPTH = 64,
  parameter int W     = 33,
  parameter int AW    = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/sfa_engine.sv
// sequencer that scans, splits, merges and shifts the segment table
// depends on sfa_pkg, sfa_ifs and the table memory at the top level
module sfa_engine
  import sfa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int UB           = 16,
  parameter int IW           = 6,
  parameter int CW           = 7
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic [UB-1:0]   region,
  input  logic            cfg_we,
  sfa_req_if.sink         req,
  output logic            res_valid,
  input  logic            res_ready,
  output status_t         res_status,
  output logic [UB-1:0]   res_offset,
  output logic [UB-1:0]   res_size,
  output logic            mem_we,
  output logic [IW-1:0]   mem_waddr,
  output logic [2*UB:0]   mem_wdata,
  output logic [IW-1:0]   mem_raddr,
  input  logic [2*UB:0]   mem_rdata
);

  typedef enum logic [16:0] {
    S_INIT = 17'b00000000000000001,
    S_IDLE = 17'b00000000000000010,
    S_RRD  = 17'b00000000000000100,
    S_REV  = 17'b00000000000001000,
    S_ARD  = 17'b00000000000010000,
    S_AEV  = 17'b00000000000100000,
    S_ADEC = 17'b00000000001000000,
    S_URD  = 17'b00000000010000000,
    S_UWR  = 17'b00000000100000000,
    S_SPL1 = 17'b00000001000000000,
    S_SPL2 = 17'b00000010000000000,
    S_FRD  = 17'b00000100000000000,
    S_FEV  = 17'b00001000000000000,
    S_FRE  = 17'b00010000000000000,
    S_FMRG = 17'b00100000000000000,
    S_DMV  = 17'b01000000000000000,
    S_RESP = 17'b10000000000000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] steps_r, steps_nxt;
  logic [UB-1:0] rover_r, rover_nxt;
  logic          rover_vld_r, rover_vld_nxt;
  strategy_t     strat_r, strat_nxt;
  logic [UB-1:0] need_r, need_nxt;
  logic [UB-1:0] where_r, where_nxt;
  logic          pick_vld_r, pick_vld_nxt;
  logic [CW-1:0] pick_idx_r, pick_idx_nxt;
  logic [UB-1:0] pick_off_r, pick_off_nxt;
  logic [UB-1:0] pick_len_r, pick_len_nxt;
  logic          prev_used_r, prev_used_nxt;
  logic [UB-1:0] prev_off_r, prev_off_nxt;
  logic [UB-1:0] prev_len_r, prev_len_nxt;
  logic          rfree_r, rfree_nxt;
  logic [UB-1:0] rlen_r, rlen_nxt;
  logic [1:0]    rm_r, rm_nxt;
  logic          dmv_rd_r, dmv_rd_nxt;
  status_t       st_r, st_nxt;
  logic [UB-1:0] roff_r, roff_nxt;
  logic [UB-1:0] rsz_r, rsz_nxt;

  logic          e_used;
  logic [UB-1:0] e_off, e_len;
  logic [CW-1:0] idx_p1, pick_p1;
  logic          fit, better, lfree;
  logic [UB+1:0] total_w;
  logic [1:0]    rm_sum;
  logic [CW-1:0] dst, src;

  assign e_used  = mem_rdata[2*UB];
  assign e_off   = mem_rdata[2*UB-1:UB];
  assign e_len   = mem_rdata[UB-1:0];
  assign idx_p1  = idx_r + CW'(1);
  assign pick_p1 = pick_idx_r + CW'(1);
  assign fit     = !e_used && (e_len >= need_r);
  assign better  = !pick_vld_r ||
                   (strat_r == STRAT_BEST  && e_len < pick_len_r) ||
                   (strat_r == STRAT_WORST && e_len > pick_len_r);

  // free merge: pick holds the hit entry, prev its left neighbor
  assign lfree   = (pick_idx_r != '0) && !prev_used_r;
  assign total_w = {2'b00, pick_len_r} + (rfree_r ? {2'b00, rlen_r} : '0) +
                   (lfree ? {2'b00, prev_len_r} : '0);
  assign rm_sum  = {1'b0, rfree_r} + {1'b0, lfree};
  assign dst     = lfree ? pick_idx_r - CW'(1) : pick_idx_r;
  assign src     = dst + CW'(1) + CW'(rm_sum);

  assign req.ready  = (state_r == S_IDLE) && !cfg_we;
  assign res_valid  = (state_r == S_RESP);
  assign res_status = st_r;
  assign res_offset = roff_r;
  assign res_size   = rsz_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    idx_nxt       = idx_r;
    steps_nxt     = steps_r;
    rover_nxt     = rover_r;
    rover_vld_nxt = rover_vld_r;
    strat_nxt     = strat_r;
    need_nxt      = need_r;
    where_nxt     = where_r;
    pick_vld_nxt  = pick_vld_r;
    pick_idx_nxt  = pick_idx_r;
    pick_off_nxt  = pick_off_r;
    pick_len_nxt  = pick_len_r;
    prev_used_nxt = prev_used_r;
    prev_off_nxt  = prev_off_r;
    prev_len_nxt  = prev_len_r;
    rfree_nxt     = rfree_r;
    rlen_nxt      = rlen_r;
    rm_nxt        = rm_r;
    dmv_rd_nxt    = dmv_rd_r;
    st_nxt        = st_r;
    roff_nxt      = roff_r;
    rsz_nxt       = rsz_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[IW-1:0];
    mem_wdata     = mem_rdata;
    mem_raddr     = idx_r[IW-1:0];

    unique case (state_r)
      S_INIT: begin
        mem_we        = 1'b1;
        mem_waddr     = '0;
        mem_wdata     = {1'b0, {UB{1'b0}}, region};
        cnt_nxt       = CW'(1);
        rover_vld_nxt = 1'b0;
        rover_nxt     = '0;
        state_nxt     = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid && !cfg_we) begin
          strat_nxt    = strategy_t'(req.strategy);
          need_nxt     = req.request_size;
          where_nxt    = req.block_offset;
          idx_nxt      = '0;
          steps_nxt    = '0;
          pick_vld_nxt = 1'b0;
          if (req.mode == MODE_FREE) begin
            state_nxt = S_FRD;
          end else if (req.request_size == '0) begin
            st_nxt    = ST_NOFIT;
            roff_nxt  = '0;
            rsz_nxt   = '0;
            state_nxt = S_RESP;
          end else if (strategy_t'(req.strategy) == STRAT_NEXT && rover_vld_r) begin
            state_nxt = S_RRD;
          end else begin
            state_nxt = S_ARD;
          end
        end
      end
      S_RRD: state_nxt = S_REV;
      S_REV: begin
        // locate the segment holding the rover, else start at the front
        if (rover_r >= e_off && (rover_r - e_off) < e_len) begin
          state_nxt = S_ARD;
        end else if (idx_p1 == cnt_r) begin
          idx_nxt   = '0;
          state_nxt = S_ARD;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_RRD;
        end
      end
      S_ARD: state_nxt = S_AEV;
      S_AEV: begin
        steps_nxt = steps_r + CW'(1);
        idx_nxt   = (idx_p1 == cnt_r) ? '0 : idx_p1;
        state_nxt = (steps_r + CW'(1) == cnt_r) ? S_ADEC : S_ARD;
        if (fit && better) begin
          pick_vld_nxt = 1'b1;
          pick_idx_nxt = idx_r;
          pick_off_nxt = e_off;
          pick_len_nxt = e_len;
          if (strat_r == STRAT_FIRST || strat_r == STRAT_NEXT) begin
            state_nxt = S_ADEC;
          end
        end
      end
      S_ADEC: begin
        if (!pick_vld_r) begin
          st_nxt    = ST_NOFIT;
          roff_nxt  = '0;
          rsz_nxt   = '0;
          state_nxt = S_RESP;
        end else if (pick_len_r > need_r) begin
          if (cnt_r >= CW'(MAX_SEGMENTS)) begin
            st_nxt    = ST_FULL;
            roff_nxt  = '0;
            rsz_nxt   = '0;
            state_nxt = S_RESP;
          end else begin
            idx_nxt   = cnt_r;
            state_nxt = (cnt_r > pick_p1) ? S_URD : S_SPL1;
          end
        end else begin
          state_nxt = S_SPL2;
        end
      end
      S_URD: begin
        mem_raddr = IW'(idx_r - CW'(1));
        state_nxt = S_UWR;
      end
      S_UWR: begin
        // open a gap above the split segment, top entry first
        mem_we    = 1'b1;
        mem_waddr = idx_r[IW-1:0];
        mem_wdata = mem_rdata;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = (idx_r - CW'(1) > pick_p1) ? S_URD : S_SPL1;
      end
      S_SPL1: begin
        mem_we    = 1'b1;
        mem_waddr = pick_p1[IW-1:0];
        mem_wdata = {1'b0, pick_off_r + need_r, pick_len_r - need_r};
        cnt_nxt   = cnt_r + CW'(1);
        state_nxt = S_SPL2;
      end
      S_SPL2: begin
        mem_we    = 1'b1;
        mem_waddr = pick_idx_r[IW-1:0];
        mem_wdata = {1'b1, pick_off_r, need_r};
        if (strat_r == STRAT_NEXT) begin
          rover_nxt     = pick_off_r;
          rover_vld_nxt = 1'b1;
        end
        st_nxt    = ST_OK;
        roff_nxt  = pick_off_r;
        rsz_nxt   = need_r;
        state_nxt = S_RESP;
      end
      S_FRD: begin
        mem_raddr = idx_r[IW-1:0];
        state_nxt = S_FEV;
      end
      S_FEV: begin
        if (e_used && e_off == where_r) begin
          pick_idx_nxt = idx_r;
          pick_off_nxt = e_off;
          pick_len_nxt = e_len;
          if (idx_p1 < cnt_r) begin
            mem_raddr = idx_p1[IW-1:0];
            state_nxt = S_FRE;
          end else begin
            rfree_nxt = 1'b0;
            state_nxt = S_FMRG;
          end
        end else begin
          prev_used_nxt = e_used;
          prev_off_nxt  = e_off;
          prev_len_nxt  = e_len;
          idx_nxt       = idx_p1;
          if (idx_p1 == cnt_r) begin
            st_nxt    = ST_BADFREE;
            roff_nxt  = '0;
            rsz_nxt   = '0;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_FRD;
          end
        end
      end
      S_FRE: begin
        rfree_nxt = !e_used;
        rlen_nxt  = e_len;
        state_nxt = S_FMRG;
      end
      S_FMRG: begin
        rm_nxt    = rm_sum;
        mem_we    = 1'b1;
        mem_waddr = dst[IW-1:0];
        mem_wdata = {1'b0, lfree ? prev_off_r : pick_off_r, total_w[UB-1:0]};
        st_nxt    = ST_OK;
        roff_nxt  = lfree ? prev_off_r : pick_off_r;
        rsz_nxt   = total_w[UB-1:0];
        idx_nxt   = src;
        dmv_rd_nxt = 1'b1;
        if (rm_sum == 2'd0) begin
          state_nxt = S_RESP;
        end else if (src < cnt_r) begin
          state_nxt = S_DMV;
        end else begin
          cnt_nxt   = cnt_r - CW'(rm_sum);
          state_nxt = S_RESP;
        end
      end
      S_DMV: begin
        // close the gap: read entry idx, then write it rm places lower
        if (dmv_rd_r) begin
          mem_raddr  = idx_r[IW-1:0];
          dmv_rd_nxt = 1'b0;
        end else begin
          mem_we     = 1'b1;
          mem_waddr  = IW'(idx_r - CW'(rm_r));
          mem_wdata  = mem_rdata;
          dmv_rd_nxt = 1'b1;
          idx_nxt    = idx_p1;
          if (idx_p1 == cnt_r) begin
            cnt_nxt   = cnt_r - CW'(rm_r);
            state_nxt = S_RESP;
          end
        end
      end
      S_RESP: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_INIT;
    endcase

    if (cfg_we) begin
      state_nxt = S_INIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      cnt_r       <= CW'(1);
      rover_vld_r <= 1'b0;
      rover_r     <= '0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      rover_vld_r <= rover_vld_nxt;
      rover_r     <= rover_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    steps_r     <= steps_nxt;
    strat_r     <= strat_nxt;
    need_r      <= need_nxt;
    where_r     <= where_nxt;
    pick_vld_r  <= pick_vld_nxt;
    pick_idx_r  <= pick_idx_nxt;
    pick_off_r  <= pick_off_nxt;
    pick_len_r  <= pick_len_nxt;
    prev_used_r <= prev_used_nxt;
    prev_off_r  <= prev_off_nxt;
    prev_len_r  <= prev_len_nxt;
    rfree_r     <= rfree_nxt;
    rlen_r      <= rlen_nxt;
    rm_r        <= rm_nxt;
    dmv_rd_r    <= dmv_rd_nxt;
    st_r        <= st_nxt;
    roff_r      <= roff_nxt;
    rsz_r       <= rsz_nxt;
  end

endmodule

// File: rtl/core/segment_fit_allocator.sv
// segment fit allocator top level: region register, result register, table memory
// depends on sfa_pkg, sfa_ifs, sfa_seg_mem and sfa_engine
//
// Manages one region of region_size units as an offset-ordered table of free
// and allocated segments kept in a single-port-read memory. One request is
// worked at a time. An allocate scans the table entry by entry (first and
// next fit stop at the first fit; next fit first scans for the entry that
// holds the rover), then, when it splits, shifts the entries above the
// chosen one up by one place. A free scans to the named segment, then after
// a merge shifts the entries above it down. A configuration write resets
// the table to one free segment of the whole region. The result waits in an
// output register, so the engine returns to idle as soon as the register
// takes it.
module segment_fit_allocator
  import sfa_pkg::*;
#(
  parameter int MAX_SEGMENTS = 64,
  parameter int UNIT_BITS    = 16
) (
  input  logic     clk,
  input  logic     rst_n,
  sfa_req_if.sink  in_req,
  sfa_rsp_if.source out_rsp,
  sfa_cfg_if.sink  cfg_wr
);

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam int EW = 2 * UNIT_BITS + 1;
  localparam logic [UNIT_BITS-1:0] RegionReset = UNIT_BITS'(1000);

  logic [UNIT_BITS-1:0] region_r, region_nxt;
  logic                 cfg_we;

  logic                 res_valid, res_ready;
  status_t              res_status;
  logic [UNIT_BITS-1:0] res_offset, res_size;

  logic                 out_vld_r, out_vld_nxt;
  logic [1:0]           out_st_r;
  logic [UNIT_BITS-1:0] out_off_r, out_sz_r;

  logic                 mem_we;
  logic [IW-1:0]        mem_waddr, mem_raddr;
  logic [EW-1:0]        mem_wdata, mem_rdata;

  assign cfg_wr.ready = 1'b1;
  assign cfg_we       = cfg_wr.valid;
  // a zero region is taken as one unit
  assign region_nxt   = cfg_we ? ((cfg_wr.data == '0) ? UNIT_BITS'(1) : cfg_wr.data)
                               : region_r;

  assign res_ready   = !out_vld_r || out_rsp.ready;
  assign out_vld_nxt = (res_valid && res_ready) ? 1'b1 :
                       (out_rsp.ready ? 1'b0 : out_vld_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      region_r  <= RegionReset;
      out_vld_r <= 1'b0;
    end else begin
      region_r  <= region_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_st_r  <= res_status;
      out_off_r <= res_offset;
      out_sz_r  <= res_size;
    end
  end

  assign out_rsp.valid         = out_vld_r;
  assign out_rsp.status        = out_st_r;
  assign out_rsp.result_offset = out_off_r;
  assign out_rsp.result_size   = out_sz_r;

  sfa_seg_mem #(
    .DEPTH(MAX_SEGMENTS),
    .W    (EW),
    .AW   (IW)
  ) u_mem (
    .clk  (clk),
    .we   (mem_we),
    .waddr(mem_waddr),
    .wdata(mem_wdata),
    .raddr(mem_raddr),
    .rdata(mem_rdata)
  );

  sfa_engine #(
    .MAX_SEGMENTS(MAX_SEGMENTS),
    .UB          (UNIT_BITS),
    .IW          (IW),
    .CW          (CW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .region    (region_r),
    .cfg_we    (cfg_we),
    .req       (in_req),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_status(res_status),
    .res_offset(res_offset),
    .res_size  (res_size),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

endmodule

// File: bench/tb_top.sv
// testbench for segment_fit_allocator: random and directed alloc/free traffic
// depends on sfa_pkg and sfa_ifs; checks every result against a local allocator model
`timescale 1ns / 100ps

import sfa_pkg::*;

typedef struct {
  logic [1:0]  status;
  logic [15:0] offset;
  logic [15:0] size;
} alloc_result_t;

class alloc_scoreboard;
  localparam int NSEG = 64;
  logic [15:0] region;
  logic [15:0] seg_off[NSEG];
  logic [15:0] seg_len[NSEG];
  bit          seg_busy[NSEG];
  int          nseg;
  logic [15:0] rover;
  bit          rover_ok;
  alloc_result_t pending[$];
  int          errors;
  int          mismatches;

  function new();
    errors = 0;
    mismatches = 0;
    set_region(16'd1000);
  endfunction

  function void set_region(logic [15:0] v);
    region = (v == 0) ? 16'd1 : v;
    nseg = 1;
    seg_off[0] = 0;
    seg_len[0] = region;
    seg_busy[0] = 0;
    rover = 0;
    rover_ok = 0;
  endfunction

  function int pick(logic [1:0] strat, logic [15:0] need);
    int p, start;
    p = -1;
    start = 0;
    if (strat == STRAT_FIRST) begin
      for (int i = 0; i < nseg; i++)
        if (!seg_busy[i] && seg_len[i] >= need) return i;
      return -1;
    end
    if (strat == STRAT_BEST || strat == STRAT_WORST) begin
      for (int i = 0; i < nseg; i++) begin
        if (seg_busy[i] || seg_len[i] < need) continue;
        if (p < 0 || (strat == STRAT_BEST && seg_len[i] < seg_len[p]) ||
            (strat == STRAT_WORST && seg_len[i] > seg_len[p]))
          p = i;
      end
      return p;
    end
    if (rover_ok) begin
      for (int i = 0; i < nseg; i++)
        if (rover >= seg_off[i] && 32'(rover) - seg_off[i] < seg_len[i]) begin
          start = i;
          break;
        end
    end
    for (int i = 0; i < nseg; i++) begin
      int j;
      j = (start + i) % nseg;
      if (!seg_busy[j] && seg_len[j] >= need) return j;
    end
    return -1;
  endfunction

  function void drop(int i);
    for (int k = i; k + 1 < nseg; k++) begin
      seg_off[k] = seg_off[k+1];
      seg_len[k] = seg_len[k+1];
      seg_busy[k] = seg_busy[k+1];
    end
    nseg--;
  endfunction

  function void note_request(logic mode, logic [1:0] strat, logic [15:0] need,
                             logic [15:0] where);
    alloc_result_t r;
    int i;
    r.status = ST_OK;
    r.offset = 0;
    r.size = 0;
    if (mode == MODE_ALLOC) begin
      i = (need == 0) ? -1 : pick(strat, need);
      if (i < 0) r.status = ST_NOFIT;
      else if (seg_len[i] > need && nseg >= NSEG) r.status = ST_FULL;
      else begin
        if (seg_len[i] > need) begin
          for (int k = nseg; k > i + 1; k--) begin
            seg_off[k] = seg_off[k-1];
            seg_len[k] = seg_len[k-1];
            seg_busy[k] = seg_busy[k-1];
          end
          seg_off[i+1] = seg_off[i] + need;
          seg_len[i+1] = seg_len[i] - need;
          seg_busy[i+1] = 0;
          seg_len[i] = need;
          nseg++;
        end
        seg_busy[i] = 1;
        if (strat == STRAT_NEXT) begin
          rover = seg_off[i];
          rover_ok = 1;
        end
        r.offset = seg_off[i];
        r.size = seg_len[i];
      end
    end else begin
      i = -1;
      for (int k = 0; k < nseg; k++)
        if (seg_busy[k] && seg_off[k] == where) begin
          i = k;
          break;
        end
      if (i < 0) r.status = ST_BADFREE;
      else begin
        seg_busy[i] = 0;
        if (i + 1 < nseg && !seg_busy[i+1]) begin
          seg_len[i] += seg_len[i+1];
          drop(i + 1);
        end
        if (i > 0 && !seg_busy[i-1]) begin
          seg_len[i-1] += seg_len[i];
          drop(i);
          i--;
        end
        r.offset = seg_off[i];
        r.size = seg_len[i];
      end
    end
    pending.push_back(r);
  endfunction

  function void check_result(logic [1:0] st, logic [15:0] off, logic [15:0] sz);
    alloc_result_t e;
    if (pending.size() == 0) begin
      errors++;
      if (mismatches++ < 10) $display("unexpected result st=%0d off=%0d sz=%0d", st, off, sz);
      return;
    end
    e = pending.pop_front();
    if (st !== e.status || off !== e.offset || sz !== e.size) begin
      errors++;
      if (mismatches++ < 10)
        $display("mismatch: expected st=%0d off=%0d sz=%0d, got st=%0d off=%0d sz=%0d",
                 e.status, e.offset, e.size, st, off, sz);
    end
  endfunction

  // pick an allocated offset to free, or a random one
  function logic [15:0] busy_offset();
    int c;
    c = 0;
    for (int i = 0; i < nseg; i++) if (seg_busy[i]) c++;
    if (c == 0 || $urandom_range(0, 9) == 0) return 16'($urandom_range(0, region));
    c = $urandom_range(0, c - 1);
    for (int i = 0; i < nseg; i++)
      if (seg_busy[i]) begin
        if (c == 0) return seg_off[i];
        c--;
      end
    return 0;
  endfunction
endclass

module tb_top;
  logic clk = 0;
  logic rst_n = 0;
  sfa_req_if #(16) req_ch();
  sfa_rsp_if #(16) rsp_ch();
  sfa_cfg_if #(16) cfg_ch();
  alloc_scoreboard board;
  bit hold_off = 0;
  bit long_hold = 0;

  always #5 clk = ~clk;

  segment_fit_allocator dut (
    .clk(clk), .rst_n(rst_n), .in_req(req_ch.sink), .out_rsp(rsp_ch.source),
    .cfg_wr(cfg_ch.sink)
  );

  initial begin
    req_ch.valid = 0;
    req_ch.mode = 0;
    req_ch.strategy = 0;
    req_ch.request_size = 0;
    req_ch.block_offset = 0;
    cfg_ch.valid = 0;
    cfg_ch.data = 0;
    rsp_ch.ready = 0;
  end

  // valid stays high after an accept so that a gap of zero gives back to back items
  task automatic send_request(logic mode, logic [1:0] strat, logic [15:0] need,
                              logic [15:0] where);
    int gap;
    gap = hold_off ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      req_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1;
    req_ch.mode <= mode;
    req_ch.strategy <= strat;
    req_ch.request_size <= need;
    req_ch.block_offset <= where;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    board.note_request(mode, strat, need, where);
  endtask

  task automatic write_region(logic [15:0] v);
    req_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    cfg_ch.valid <= 1;
    cfg_ch.data <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    board.set_region(v);
    cfg_ch.valid <= 0;
  endtask

  // result side: random stalls plus one long hold-off
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      if (long_hold) begin
        rsp_ch.ready <= 0;
        repeat (2000) @(posedge clk);
        long_hold = 0;
      end
      w = hold_off ? 0 : $urandom_range(0, 13);
      if (w > 0) begin
        rsp_ch.ready <= 0;
        repeat (w) @(posedge clk);
      end
      rsp_ch.ready <= 1;
      @(posedge clk);
      if (rsp_ch.valid) board.check_result(rsp_ch.status, rsp_ch.result_offset,
                                            rsp_ch.result_size);
    end
  end

  task automatic random_phase(int n);
    logic [15:0] sz;
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 100) hold_off = ~hold_off;
      if ($urandom_range(0, 1)) begin
        case ($urandom_range(0, 9))
          0: sz = 16'($urandom());
          1: sz = 0;
          default: sz = 16'($urandom_range(1, board.region / 8 + 1));
        endcase
        send_request(MODE_ALLOC, 2'($urandom_range(0, 3)), sz, 16'($urandom()));
      end else begin
        send_request(MODE_FREE, 2'($urandom_range(0, 3)), 16'($urandom()),
                     board.busy_offset());
      end
    end
  endtask

  initial begin
    board = new();
    repeat (2) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: every strategy, zero size, too large, bad free, exact fit, merges
    send_request(MODE_ALLOC, STRAT_FIRST, 16'd0, 16'd0);
    send_request(MODE_ALLOC, STRAT_FIRST, 16'hffff, 16'hffff);
    send_request(MODE_ALLOC, STRAT_FIRST, 16'd100, 16'd0);
    send_request(MODE_ALLOC, STRAT_NEXT, 16'd50, 16'd0);
    send_request(MODE_ALLOC, STRAT_BEST, 16'd200, 16'd0);
    send_request(MODE_ALLOC, STRAT_WORST, 16'd30, 16'd0);
    send_request(MODE_FREE, STRAT_NEXT, 16'd0, 16'd100);
    send_request(MODE_FREE, STRAT_FIRST, 16'd0, 16'd100);
    send_request(MODE_FREE, STRAT_FIRST, 16'd0, 16'd7);
    send_request(MODE_ALLOC, STRAT_BEST, 16'd40, 16'd0);
    send_request(MODE_ALLOC, STRAT_NEXT, 16'd20, 16'd0);
    send_request(MODE_FREE, STRAT_FIRST, 16'd0, 16'd0);
    send_request(MODE_FREE, STRAT_FIRST, 16'd0, 16'd150);
    send_request(MODE_ALLOC, STRAT_FIRST, 16'd620, 16'd0);
    send_request(MODE_ALLOC, STRAT_NEXT, 16'd1, 16'd0);
    write_region(16'd0);
    send_request(MODE_ALLOC, STRAT_WORST, 16'd1, 16'd0);
    send_request(MODE_FREE, STRAT_WORST, 16'd0, 16'd0);
    write_region(16'hffff);
    send_request(MODE_ALLOC, STRAT_NEXT, 16'hffff, 16'd0);
    send_request(MODE_FREE, STRAT_FIRST, 16'd0, 16'd0);
    // fill the table with small runs to reach table full
    write_region(16'd100);
    for (int i = 0; i < 66; i++) send_request(MODE_ALLOC, STRAT_FIRST, 16'd1, 16'd0);
    random_phase(150);
    write_region(16'd300);
    long_hold = 1;
    random_phase(500);
    write_region(16'($urandom_range(1, 65535)));
    random_phase(400);
    write_region(16'd1000);
    random_phase(500);
    req_ch.valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    if (board.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    #50ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/sfa_pkg.sv
rtl/core/sfa_ifs.sv
rtl/core/sfa_seg_mem.sv
rtl/core/sfa_engine.sv
rtl/core/segment_fit_allocator.sv
bench/tb_top.sv
